[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// condition must never be true outside reset
`define AST_NEVER(lbl, clk, rst_n, cond) \
  `AST_CLK(lbl, clk, rst_n, !(cond))

`endif

[rtl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg
// Types and constants shared by the framed packet deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpd_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 1'd1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LEN = 2'd1,
    ST_END = 2'd2,
    ST_CHK = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] module_id;
    logic [7:0]  len;
    logic        bank;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

endpackage

[rtl/framed_packet_deframer.sv]
// ----------------------------------------------------------------------------
// framed_packet_deframer
// Deframes a received byte stream and emits checked payload bytes, or one
// result per frame for an error or an empty payload.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. A parser checks framing, length and
// the XOR checksum and writes payload bytes into one of two RAM banks; a
// two-entry job queue hands finished frames to a sequencer that reads the
// bank back and drives one result per cycle, unless the output stalls,
// through an output register. With the result side idle, a single result
// goes from the queue into the output register, and a payload run's first
// byte also passes the run state and RAM read register. The input stalls
// only when the job queue is full as the high length byte or end marker
// arrives, or when the parser reaches payload while the bank it would
// write is still being read out, so long payloads with short gaps pace the
// input at about one byte per result. No clearing pass runs after reset.
`timescale 1ns / 1ps

module framed_packet_deframer import fpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [15:0]           out_module_id,
  output logic [5:0]            out_payload_length,
  output logic [5:0]            out_byte_index,
  output logic [7:0]            out_payload_byte,
  output logic                  out_last
);

  localparam int IW = $clog2(MAX_PAYLOAD > 1 ? MAX_PAYLOAD : 2);
  localparam int AW = IW + 1;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          q_push;
  job_t          q_push_job;
  logic          q_full;
  logic          q_pop;
  job_t          q_pop_job;
  logic          q_empty;
  bank_rel_t     rel;

  fpd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_push    (q_push),
    .q_job     (q_push_job),
    .q_full    (q_full),
    .rel       (rel)
  );

  fpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_push_job),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (q_pop_job),
    .empty   (q_empty)
  );

  fpd_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fpd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (!q_empty),
    .job               (q_pop_job),
    .job_pop           (q_pop),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .rel               (rel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_module_id     (out_module_id),
    .out_payload_length(out_payload_length),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_last          (out_last)
  );

endmodule

[rtl/fpd_ram.sv]
// ----------------------------------------------------------------------------
// fpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/fpd_front.sv]
// ----------------------------------------------------------------------------
// fpd_front
// Frame parser: tracks byte position, collects header fields, stores the
// payload into the free bank and queues one job per finished frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpd_front import fpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          ram_we,
  output logic [$clog2(MAX_PAYLOAD > 1 ? MAX_PAYLOAD : 2):0] ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic                          q_push,
  output job_t                          q_job,
  input  logic                          q_full,
  input  bank_rel_t                     rel
);

  localparam int IW = $clog2(MAX_PAYLOAD > 1 ? MAX_PAYLOAD : 2);
  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int PW = $clog2(MAX_PAYLOAD + 8);

  logic [7:0]    start_r;
  logic [7:0]    end_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   id_r, id_nxt;
  logic [7:0]    len_lo_r, len_lo_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    chk_r, chk_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic          accept;
  logic          is_idle;
  logic          is_hdr;
  logic          is_pay;
  logic          is_chk;
  logic          is_end;
  logic [PW-1:0] end_pay;
  logic [15:0]   full_len;
  logic          too_long;
  logic [7:0]    xor_in;
  status_t       end_status;

  assign end_pay  = PW'(6) + PW'(len_r);
  assign is_idle  = (pos_r == '0);
  assign is_hdr   = !is_idle && (pos_r <= PW'(5));
  assign is_pay   = !is_idle && !is_hdr && (pos_r < end_pay);
  assign is_chk   = !is_idle && !is_hdr && (pos_r == end_pay);
  assign is_end   = !is_idle && !is_hdr && !is_pay && !is_chk;
  assign full_len = {in_rx_byte, len_lo_r};
  assign too_long = (full_len > 16'(MAX_PAYLOAD));
  assign xor_in   = xor_r ^ in_rx_byte;

  assign in_stall = (((pos_r == PW'(5)) || is_end) && q_full) || (is_pay && busy_r[bank_r]);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (in_rx_byte != end_r) begin
      end_status = ST_END;
    end else if (xor_r != chk_r) begin
      end_status = ST_CHK;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    xor_nxt    = xor_r;
    chk_nxt    = chk_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    ram_we     = 1'b0;
    ram_waddr  = {bank_r, IW'(pos_r - PW'(6))};
    ram_wdata  = in_rx_byte;
    q_push     = 1'b0;
    q_job      = '{status: ST_OK, module_id: id_r, len: 8'(len_r), bank: bank_r};

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (is_idle) begin
        if (in_rx_byte == start_r) begin
          pos_nxt = PW'(1);
          xor_nxt = '0;
        end
      end else if (is_hdr) begin
        xor_nxt = xor_in;
        pos_nxt = pos_r + PW'(1);
        if (pos_r == PW'(2)) begin
          id_nxt = {id_r[15:8], in_rx_byte};
        end else if (pos_r == PW'(3)) begin
          id_nxt = {in_rx_byte, id_r[7:0]};
        end else if (pos_r == PW'(4)) begin
          len_lo_nxt = in_rx_byte;
        end else if (pos_r == PW'(5)) begin
          if (too_long) begin
            // drop the frame and retry this byte as a start marker
            q_push = 1'b1;
            q_job  = '{status: ST_LEN, module_id: id_r, len: 8'd0, bank: 1'b0};
            if (in_rx_byte == start_r) begin
              pos_nxt = PW'(1);
              xor_nxt = '0;
            end else begin
              pos_nxt = '0;
            end
          end else begin
            len_nxt = LW'(full_len);
          end
        end
      end else if (is_pay) begin
        ram_we  = 1'b1;
        xor_nxt = xor_in;
        pos_nxt = pos_r + PW'(1);
      end else if (is_chk) begin
        chk_nxt = in_rx_byte;
        pos_nxt = pos_r + PW'(1);
      end else begin
        pos_nxt      = '0;
        q_push       = 1'b1;
        q_job.status = end_status;
        if ((end_status == ST_OK) && (len_r != '0)) begin
          bank_nxt         = !bank_r;
          busy_nxt[bank_r] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      pos_r    <= '0;
      id_r     <= '0;
      len_lo_r <= '0;
      len_r    <= '0;
      xor_r    <= '0;
      chk_r    <= '0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_START_MARKER)) begin
        start_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_END_MARKER)) begin
        end_r <= cfg_data;
      end
      pos_r    <= pos_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      xor_r    <= xor_nxt;
      chk_r    <= chk_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

[rtl/fpd_queue.sv]
// ----------------------------------------------------------------------------
// fpd_queue
// Short job queue between the frame parser and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpd_queue import fpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  job_t           mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wp_r;
  logic [QPW-1:0] rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/fpd_back.sv]
// ----------------------------------------------------------------------------
// fpd_back
// Result sequencer: takes jobs from the queue, reads stored payload bytes
// and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpd_back import fpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  output logic        ram_re,
  output logic [$clog2(MAX_PAYLOAD > 1 ? MAX_PAYLOAD : 2):0] ram_raddr,
  input  logic [7:0]  ram_rdata,
  output bank_rel_t   rel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_module_id,
  output logic [5:0]  out_payload_length,
  output logic [5:0]  out_byte_index,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);

  localparam int IW = $clog2(MAX_PAYLOAD > 1 ? MAX_PAYLOAD : 2);
  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  bk_state_t     state_r, state_nxt;
  logic [15:0]   id_r;
  logic [LW-1:0] len_r;
  logic          bank_r;
  logic [IW-1:0] idx_r;
  logic          pend_r;
  logic [IW-1:0] pend_idx_r;
  logic          pend_last_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_id_r;
  logic [5:0]    out_len_r;
  logic [5:0]    out_idx_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          out_free;
  logic          xfer;
  logic          can_issue;
  logic          last_idx;
  logic          job_simple;
  logic          direct_load;
  logic          run_start;

  assign out_free   = !out_valid_r || !out_stall;
  assign xfer       = pend_r && out_free;
  assign can_issue  = !pend_r || xfer;
  assign last_idx   = ((LW'(idx_r) + LW'(1)) == len_r);
  assign job_simple = (job.status != ST_OK) || (job.len == 8'd0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (job_valid && !pend_r && !job_simple) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (can_issue && last_idx) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop     = 1'b0;
    direct_load = 1'b0;
    run_start   = 1'b0;
    ram_re      = 1'b0;
    rel         = '{valid: 1'b0, bank: bank_r};
    case (state_r)
      BK_IDLE: begin
        if (job_valid && !pend_r) begin
          if (job_simple) begin
            job_pop     = out_free;
            direct_load = out_free;
          end else begin
            job_pop   = 1'b1;
            run_start = 1'b1;
          end
        end
      end
      BK_RUN: begin
        ram_re    = can_issue;
        rel.valid = can_issue && last_idx;
      end
      default: ;
    endcase
  end

  assign ram_raddr = {bank_r, idx_r};

  always_ff @(posedge clk) begin
    if (run_start) begin
      id_r   <= job.module_id;
      len_r  <= LW'(job.len);
      bank_r <= job.bank;
    end
    if (run_start) begin
      idx_r <= '0;
    end else if (ram_re) begin
      idx_r <= idx_r + IW'(1);
    end
    if (ram_re) begin
      pend_idx_r  <= idx_r;
      pend_last_r <= last_idx;
    end
    if (direct_load) begin
      out_status_r <= job.status;
      out_id_r     <= job.module_id;
      out_len_r    <= 6'(job.len);
      out_idx_r    <= '0;
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (xfer) begin
      out_status_r <= ST_OK;
      out_id_r     <= id_r;
      out_len_r    <= 6'(len_r);
      out_idx_r    <= 6'(pend_idx_r);
      out_byte_r   <= ram_rdata;
      out_last_r   <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_re) begin
        pend_r <= 1'b1;
      end else if (xfer) begin
        pend_r <= 1'b0;
      end
      if (direct_load || xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_module_id      = out_id_r;
  assign out_payload_length = out_len_r;
  assign out_byte_index     = out_idx_r;
  assign out_payload_byte   = out_byte_r;
  assign out_last           = out_last_r;

endmodule

[rtl/fpd_checker.sv]
// ----------------------------------------------------------------------------
// fpd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpd_checker import fpd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [15:0] out_module_id,
  input logic [5:0]  out_payload_length,
  input logic [5:0]  out_byte_index,
  input logic [7:0]  out_payload_byte,
  input logic        out_last
);

  logic [38:0] out_word;
  logic        err_shape_bad;
  logic        len_err_bad;
  logic        last_index_bad;

  assign out_word = {out_status, out_module_id, out_payload_length, out_byte_index,
                     out_payload_byte, out_last};

  assign err_shape_bad = out_valid && (out_status != ST_OK) &&
                         !(out_last && (out_payload_byte == 8'd0) && (out_byte_index == 6'd0));

  assign len_err_bad = out_valid && (out_status == ST_LEN) && (out_payload_length != 6'd0);

  assign last_index_bad = out_valid && (out_status == ST_OK) && out_last &&
                          (out_payload_length != 6'd0) &&
                          ((out_byte_index + 6'd1) != out_payload_length);

  `AST_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word))
  `AST_NEVER(a_err_single, clk, rst_n, err_shape_bad)
  `AST_NEVER(a_len_err_zero, clk, rst_n, len_err_bad)
  `AST_NEVER(a_last_index, clk, rst_n, last_index_bad)

endmodule

bind framed_packet_deframer fpd_checker u_fpd_checker (.*);
